[hw/rtl/drr_pkg.sv]
// Package for the decimal rescale and round block.
// Holds the request and result payload types and the fixed arithmetic constants.
// Used by the channel interfaces and by decimal_rescale_round_top.
package drr_pkg;

    typedef struct packed {
        logic [63:0] mant_low;
        logic [63:0] mant_mid;
        logic [63:0] mant_top;
        logic [5:0]  scale_in;
        logic        negative_in;
    } t_in;

    typedef struct packed {
        logic [63:0] res_low;
        logic [31:0] res_high;
        logic [4:0]  res_scale;
        logic        res_negative;
        logic        overflow;
    } t_out;

    localparam int MANT_W      = 192;
    localparam int RES_W       = 96;
    localparam int LIMB_W      = 24;
    localparam int NUM_LIMBS   = MANT_W / LIMB_W;
    localparam int STEP_W      = LIMB_W + 4;
    localparam int RECIP_SHIFT = 31;

    localparam logic [5:0]         MAX_SCALE = 6'd28;
    localparam logic [3:0]         TIE_DIGIT = 4'd5;
    localparam logic [4:0]         TEN       = 5'd10;
    localparam logic [STEP_W-1:0]  RECIP_TEN = 28'd214748364;
    localparam logic [63:0]        CARRY_LOW  = 64'h999999999999999A;
    localparam logic [31:0]        CARRY_HIGH = 32'h19999999;

endpackage

[hw/rtl/drr_if.sv]
// Valid/ready channel interfaces for the decimal rescale and round block.
// One interface carries a request, the other a result; both depend on drr_pkg.
interface drr_in_if;
    logic          valid;
    logic          ready;
    drr_pkg::t_in  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface drr_out_if;
    logic          valid;
    logic          ready;
    drr_pkg::t_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/decimal_rescale_round_top.sv]
// Decimal rescale and round, top level.
// Narrows a 192-bit decimal mantissa to 96 bits with round half to even.
// Depends on drr_pkg and on the channel interfaces in drr_if.sv.
//
// i_req carries one request: a 192-bit unsigned mantissa, its decimal scale
// and a sign. o_res returns one result per request: a 96-bit mantissa, the
// reduced scale, the sign and an overflow flag. Both channels move a request
// at a rising edge where valid and ready are high.
// The block works on one request at a time. Each removed decimal digit takes
// eight passes of a shared 24-bit divide-by-ten step over the limbs of the
// mantissa, and one check; i_req is not ready while a request is in work.
// The result sits in an output register, so i_req takes a new request while
// an earlier result still waits. When o_res is stalled, a finished request
// holds in its rounding step until the output register frees up.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_res.valid.
module decimal_rescale_round_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    drr_in_if.sink           i_req,
    drr_out_if.source        o_res
);
    import drr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_ROUND = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [MANT_W-1:0]   r_m, n_m;
    logic [5:0]          r_scale, n_scale;
    logic                r_neg, n_neg;
    logic [3:0]          r_last, n_last;
    logic                r_sticky, n_sticky;
    logic                r_ovf, n_ovf;
    logic [3:0]          r_rem, n_rem;
    logic [2:0]          r_cnt, n_cnt;
    t_out                r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic [STEP_W-1:0]   w_x;
    logic [2*STEP_W-1:0] w_prod;
    logic [LIMB_W-1:0]   w_q0;
    logic [STEP_W-1:0]   w_diff;
    logic [4:0]          w_r0;
    logic [LIMB_W-1:0]   w_q;
    logic [3:0]          w_rem;
    logic                w_up;
    logic [RES_W:0]      w_sum;
    logic                w_load;

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        w_x    = {r_rem, r_m[MANT_W-1 -: LIMB_W]};
        w_prod = w_x * RECIP_TEN;
        w_q0   = w_prod[RECIP_SHIFT +: LIMB_W];
        w_diff = w_x - (STEP_W'({w_q0, 3'b000}) + STEP_W'({w_q0, 1'b0}));
        w_r0   = w_diff[4:0];
        if (w_r0 >= TEN) begin
            w_q   = w_q0 + LIMB_W'(1);
            w_rem = 4'(w_r0 - TEN);
        end else begin
            w_q   = w_q0;
            w_rem = w_r0[3:0];
        end
    end

    always_comb begin
        w_up = (r_last > TIE_DIGIT) ||
               ((r_last == TIE_DIGIT) && (r_sticky || r_m[0]));
        w_sum  = {1'b0, r_m[RES_W-1:0]} + (RES_W+1)'(w_up);
        w_load = !r_out_valid || o_res.ready;
    end

    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_scale     = r_scale;
        n_neg       = r_neg;
        n_last      = r_last;
        n_sticky    = r_sticky;
        n_ovf       = r_ovf;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_m      = {i_req.payload.mant_top, i_req.payload.mant_mid,
                                i_req.payload.mant_low};
                    n_scale  = i_req.payload.scale_in;
                    n_neg    = i_req.payload.negative_in;
                    n_last   = '0;
                    n_sticky = 1'b0;
                    n_ovf    = 1'b0;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((|r_m[MANT_W-1:RES_W]) || (r_scale > MAX_SCALE)) begin
                    if (r_scale == '0) begin
                        n_ovf   = 1'b1;
                        n_state = S_ROUND;
                    end else begin
                        n_sticky = r_sticky || (r_last != '0);
                        n_rem    = '0;
                        n_cnt    = '0;
                        n_scale  = r_scale - 6'd1;
                        n_state  = S_DIV;
                    end
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_DIV: begin
                n_m   = {r_m[MANT_W-LIMB_W-1:0], w_q};
                n_rem = w_rem;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'(NUM_LIMBS - 1)) begin
                    n_last  = w_rem;
                    n_state = S_CHECK;
                end
            end
            S_ROUND: begin
                if (w_load) begin
                    n_out.res_negative = r_neg;
                    if (r_ovf || (w_sum[RES_W] && (r_scale == '0))) begin
                        n_out.res_low   = '0;
                        n_out.res_high  = '0;
                        n_out.res_scale = '0;
                        n_out.overflow  = 1'b1;
                    end else if (w_sum[RES_W]) begin
                        n_out.res_low   = CARRY_LOW;
                        n_out.res_high  = CARRY_HIGH;
                        n_out.res_scale = 5'(r_scale - 6'd1);
                        n_out.overflow  = 1'b0;
                    end else begin
                        n_out.res_low   = w_sum[63:0];
                        n_out.res_high  = w_sum[RES_W-1:64];
                        n_out.res_scale = r_scale[4:0];
                        n_out.overflow  = 1'b0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_m      <= n_m;
        r_scale  <= n_scale;
        r_neg    <= n_neg;
        r_last   <= n_last;
        r_sticky <= n_sticky;
        r_ovf    <= n_ovf;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

endmodule
